/* hw/rtl/bitmap_to_pair_row_packer_defines.svh */
// Assertion macros shared by the pair-row packer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BITMAP_TO_PAIR_ROW_PACKER_DEFINES_SVH
`define BITMAP_TO_PAIR_ROW_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define BPR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BPR_ASSERT(lbl, clk, rst, prop, msg)
`define BPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/bpr_pkg.sv */
// Package for the pair-row packer: sizes, register indexes, job type, weave function.
// Depends on nothing; imported by every module of the block except bpr_ram.
package bpr_pkg;

  localparam int MAX_WIDTH     = 512;
  localparam int MAX_PAIR_ROWS = 256;

  // Field widths fixed by the interface.
  localparam int BYTE_W   = 8;
  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 9;
  localparam int CFG_W    = 10;
  localparam int CIDX_W   = 2;

  localparam int STORE_DEPTH = (MAX_WIDTH + 7) / 8;
  localparam int COL_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PAIR_W = (MAX_PAIR_ROWS > 1) ? $clog2(MAX_PAIR_ROWS) : 1;

  // Width arithmetic is done wide enough for both the register and the cap.
  localparam int EFF_W = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;
  localparam int HC_W  = (PAIR_W + 1 > HEIGHT_W) ? PAIR_W + 1 : HEIGHT_W;
  localparam int WIDTH_CAP = MAX_WIDTH - (MAX_WIDTH % 4);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH_PIXELS  = 2'd0,
    REG_HEIGHT_PAIRS  = 2'd1,
    REG_INVERT_PIXELS = 2'd2
  } reg_index_t;

  // One odd-row source byte with its stored even-row partner.
  typedef struct packed {
    logic [BYTE_W-1:0] even_byte;
    logic [BYTE_W-1:0] odd_byte;
    logic              two_out;
    logic              frame_end;
  } job_t;

  // Even-row pixel i goes to bit 7-2i, odd-row pixel i to bit 6-2i.
  function automatic logic [BYTE_W-1:0] weave(input logic [3:0] even_nib,
                                              input logic [3:0] odd_nib);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[7 - 2*i] = even_nib[3 - i];
      r[6 - 2*i] = odd_nib[3 - i];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bpr_if.sv */
// Valid/ready channel interfaces for source bytes and packed bytes.
// Depends on bpr_pkg for field widths.
interface bpr_src_if;
  import bpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface bpr_pkd_if;
  import bpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_item;
  logic              last_of_frame;
  modport source (output valid, output packed_byte, output last_of_item,
                  output last_of_frame, input ready);
  modport sink (input valid, input packed_byte, input last_of_item,
                input last_of_frame, output ready);
endinterface

/* hw/rtl/bitmap_to_pair_row_packer.sv */
// Pair-row packer: 1-bpp row-major bitmap bytes in, 2-row by 4-column panel bytes out.
// An odd-row byte passes the line store read, the job queue and the output register
// before its first packed byte is presented. Throughput: one source byte per cycle
// while the queue has room, and one packed byte per cycle while the panel is ready.
// Reset (synchronous, active high) restores default geometry and frame start; the
// line store is not cleared, since each odd row reads only what its even row wrote.
module bitmap_to_pair_row_packer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bpr_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bpr_pkg::CFG_W-1:0]  cfg_data,
  bpr_src_if.sink                    source,
  bpr_pkd_if.source                  panel
);
  import bpr_pkg::*;

  // Jobs are odd-row source bytes paired with the even-row byte of the same
  // column. Even-row bytes only update the line store and never reach the queue.
  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              head;
  logic              not_empty;
  logic [QCNT_W-1:0] q_count;

  // The front end owns the configuration registers, the column/row counters and
  // the line store. It starts the store read on acceptance and pushes the finished
  // job in the cycle after; its ready counts that read stage against free queue slots.
  bpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .source   (source),
    .q_count  (q_count),
    .push     (push),
    .push_job (push_job)
  );

  // The queue lets the front keep taking source bytes while the output side stalls,
  // until it fills, and absorbs the two-bytes-per-job rate of odd rows.
  bpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .not_empty(not_empty),
    .count    (q_count)
  );

  // The back end emits the high-nibble byte and, when the column's right half is
  // inside the width, the low-nibble byte, flagging the item and frame ends.
  bpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .not_empty(not_empty),
    .pop      (pop),
    .panel    (panel)
  );
endmodule

/* hw/rtl/bpr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module bpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/bpr_front.sv */
// Front end: configuration, frame position tracking, even-row line store, job issue.
// Depends on bpr_pkg, bpr_src_if and bpr_ram.
module bpr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bpr_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bpr_pkg::CFG_W-1:0]  cfg_data,
  bpr_src_if.sink                    source,
  input  logic [bpr_pkg::QCNT_W-1:0] q_count,
  output logic                       push,
  output bpr_pkg::job_t              push_job
);
  import bpr_pkg::*;

  logic [WIDTH_W-1:0]  width_pixels;
  logic [HEIGHT_W-1:0] height_pairs;
  logic                invert_pixels;
  logic [COL_W-1:0]    byte_column;
  logic                odd_row_flag;
  logic [PAIR_W-1:0]   pair_row_count;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_src;
  logic              s1_two;
  logic              s1_fe;
  logic [BYTE_W-1:0] even_rd;

  logic [EFF_W-1:0]  w_clr;
  logic [EFF_W-1:0]  w_eff;
  logic [EFF_W:0]    nbytes_m1;
  logic [COL_W-1:0]  last_col;
  logic [COL_W-1:0]  col;
  logic [EFF_W:0]    col_end_px;
  logic              two_out;
  logic              row_end;
  logic [HC_W-1:0]   h_ext;
  logic [PAIR_W-1:0] h_last;
  logic              pair_last;
  logic              frame_end;
  logic [BYTE_W-1:0] src;
  logic              acc;
  logic [QCNT_W:0]   in_flight;

  always_comb begin
    w_clr = EFF_W'({width_pixels[WIDTH_W-1:2], 2'b00});
    if (w_clr == '0) begin
      w_eff = EFF_W'(4);
    end else if (w_clr > EFF_W'(WIDTH_CAP)) begin
      w_eff = EFF_W'(WIDTH_CAP);
    end else begin
      w_eff = w_clr;
    end
    nbytes_m1 = ((EFF_W+1)'(w_eff) + (EFF_W+1)'(7)) >> 3;
    nbytes_m1 = nbytes_m1 - (EFF_W+1)'(1);
    last_col  = nbytes_m1[COL_W-1:0];
    col       = (byte_column > last_col) ? last_col : byte_column;
    row_end   = (col == last_col);
    // The second half of a byte exists when its four pixels lie inside the width.
    col_end_px = ((EFF_W+1)'(col) << 3) + (EFF_W+1)'(8);
    two_out    = ((EFF_W+1)'(w_eff) >= col_end_px);

    h_ext = HC_W'(height_pairs);
    if (h_ext == '0) begin
      h_last = '0;
    end else if (h_ext >= HC_W'(MAX_PAIR_ROWS)) begin
      h_last = PAIR_W'(MAX_PAIR_ROWS - 1);
    end else begin
      h_last = PAIR_W'(h_ext - HC_W'(1));
    end
    pair_last = (pair_row_count >= h_last);
    frame_end = row_end && pair_last;
    src = invert_pixels ? ~source.source_byte : source.source_byte;
  end

  // Credit check: a job in the read stage still needs a queue slot.
  assign in_flight    = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid);
  assign source.ready = (in_flight < (QCNT_W+1)'(QDEPTH));
  assign acc          = source.valid && source.ready;

  bpr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (acc && !odd_row_flag),
    .waddr(col),
    .wdata(src),
    .re   (acc && odd_row_flag),
    .raddr(col),
    .rdata(even_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels   <= WIDTH_W'(168);
      height_pairs   <= HEIGHT_W'(200);
      invert_pixels  <= 1'b0;
      byte_column    <= '0;
      odd_row_flag   <= 1'b0;
      pair_row_count <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= acc && odd_row_flag;
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH_PIXELS: begin
            width_pixels   <= cfg_data[WIDTH_W-1:0];
            byte_column    <= '0;
            odd_row_flag   <= 1'b0;
            pair_row_count <= '0;
          end
          REG_HEIGHT_PAIRS: begin
            height_pairs   <= cfg_data[HEIGHT_W-1:0];
            byte_column    <= '0;
            odd_row_flag   <= 1'b0;
            pair_row_count <= '0;
          end
          REG_INVERT_PIXELS: begin
            invert_pixels <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end else if (acc) begin
        if (row_end) begin
          byte_column  <= '0;
          odd_row_flag <= !odd_row_flag;
          if (odd_row_flag) begin
            pair_row_count <= pair_last ? '0 : pair_row_count + PAIR_W'(1);
          end
        end else begin
          byte_column <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && odd_row_flag) begin
      s1_src <= src;
      s1_two <= two_out;
      s1_fe  <= frame_end;
    end
  end

  assign push               = s1_valid;
  assign push_job.even_byte = even_rd;
  assign push_job.odd_byte  = s1_src;
  assign push_job.two_out   = s1_two;
  assign push_job.frame_end = s1_fe;
endmodule

/* hw/rtl/bpr_queue.sv */
// Short job queue between the front end and the output stage.
// Depends on bpr_pkg and the assertion macro header.
`include "bitmap_to_pair_row_packer_defines.svh"
module bpr_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bpr_pkg::job_t              push_job,
  input  logic                       pop,
  output bpr_pkg::job_t              head,
  output logic                       not_empty,
  output logic [bpr_pkg::QCNT_W-1:0] count
);
  import bpr_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `BPR_ASSERT(a_no_overflow, clk, rst, !(push && !pop && count == QCNT_W'(QDEPTH)), "queue overflow")
  `BPR_ASSERT(a_no_underflow, clk, rst, !(pop && count == '0), "queue underflow")
  `BPR_ASSERT_NEXT(a_push_counts, clk, rst, push && !pop, count == $past(count) + QCNT_W'(1), "push lost")
endmodule

/* hw/rtl/bpr_back.sv */
// Output stage: weaves each job into one or two packed bytes behind an output register.
// Depends on bpr_pkg and bpr_pkd_if.
module bpr_back (
  input  logic          clk,
  input  logic          rst,
  input  bpr_pkg::job_t head,
  input  logic          not_empty,
  output logic          pop,
  bpr_pkd_if.source     panel
);
  import bpr_pkg::*;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_item;
  logic              out_last_frame;
  logic              second_half;
  logic              load;

  assign load = not_empty && (!out_valid || panel.ready);
  assign pop  = load && (second_half || !head.two_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      second_half <= 1'b0;
    end else begin
      if (load) begin
        out_valid   <= 1'b1;
        second_half <= !second_half && head.two_out;
      end else if (panel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_half) begin
        out_byte       <= weave(head.even_byte[3:0], head.odd_byte[3:0]);
        out_last_item  <= 1'b1;
        out_last_frame <= head.frame_end;
      end else begin
        out_byte       <= weave(head.even_byte[7:4], head.odd_byte[7:4]);
        out_last_item  <= !head.two_out;
        out_last_frame <= !head.two_out && head.frame_end;
      end
    end
  end

  assign panel.valid         = out_valid;
  assign panel.packed_byte   = out_byte;
  assign panel.last_of_item  = out_last_item;
  assign panel.last_of_frame = out_last_frame;
endmodule
